FILE: rtl/core/rlmp_pkg.sv
`default_nettype none
package rlmp_pkg;

    localparam int CharW   = 8;
    localparam int MaskW   = 16;
    localparam int BankW   = 8;
    localparam int StatusW = 2;

    localparam logic [CharW-1:0] ChNone  = 8'h00;
    localparam logic [CharW-1:0] ChD     = 8'h64;
    localparam logic [CharW-1:0] ChA     = 8'h61;
    localparam logic [CharW-1:0] ChDash  = 8'h2D;
    localparam logic [CharW-1:0] ChComma = 8'h2C;
    localparam logic [CharW-1:0] ChSlash = 8'h2F;
    localparam logic [CharW-1:0] ChZero  = 8'h30;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DIGIT   = 2'd1,
        PH_RLETTER = 2'd2,
        PH_RDIGIT  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        BANK_NONE = 2'd0,
        BANK_D    = 2'd1,
        BANK_A    = 2'd2
    } t_bank;

    typedef enum logic [StatusW-1:0] {
        ST_OK      = 2'd0,
        ST_SYNTAX  = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    typedef struct packed {
        t_phase           phase;
        logic             pending_bank;
        t_bank            recent_bank;
        logic [2:0]       recent_index;
        logic [MaskW-1:0] mask_accum;
        t_status          err_code;
    } t_parse_state;

    localparam t_parse_state StateReset = '{
        phase:        PH_IDLE,
        pending_bank: 1'b0,
        recent_bank:  BANK_NONE,
        recent_index: 3'd0,
        mask_accum:   '0,
        err_code:     ST_OK
    };

endpackage
`default_nettype wire

FILE: rtl/core/rlmp_step.sv
`default_nettype none
module rlmp_step (
    input  rlmp_pkg::t_parse_state       i_state,
    input  logic [rlmp_pkg::CharW-1:0]   i_char,
    output rlmp_pkg::t_parse_state       o_state
);
    import rlmp_pkg::*;

    logic [CharW-1:0] digit_raw;
    logic             digit_ok;
    logic [2:0]       digit;
    logic [2:0]       lo;
    logic [2:0]       hi;
    logic [BankW-1:0] span;
    logic [MaskW-1:0] single_bit;
    logic [MaskW-1:0] range_bits;

    assign digit_raw = i_char - ChZero;
    assign digit_ok  = (digit_raw[CharW-1:3] == '0);
    assign digit     = digit_raw[2:0];
    assign lo        = (digit < i_state.recent_index) ? digit : i_state.recent_index;
    assign hi        = (digit < i_state.recent_index) ? i_state.recent_index : digit;
    assign span      = (8'hFF >> (3'd7 - hi)) & (8'hFF << lo);

    assign single_bit = i_state.pending_bank ? {8'b0000_0001 << digit, 8'h00}
                                             : {8'h00, 8'b0000_0001 << digit};
    assign range_bits = (i_state.recent_bank == BANK_A) ? {span, 8'h00} : {8'h00, span};

    always_comb begin
        o_state = i_state;
        if (i_state.err_code == ST_OK && i_char != ChNone) begin
            case (i_state.phase)
                PH_IDLE: begin
                    if (i_char == ChD || i_char == ChA) begin
                        o_state.pending_bank = (i_char == ChA);
                        o_state.phase        = PH_DIGIT;
                    end else if (i_char == ChDash) begin
                        if (i_state.recent_bank == BANK_NONE) begin
                            o_state.err_code = ST_SYNTAX;
                        end else begin
                            o_state.phase = PH_RLETTER;
                        end
                    end else if (i_char != ChComma && i_char != ChSlash) begin
                        o_state.err_code = ST_UNKNOWN;
                    end
                end
                PH_DIGIT: begin
                    if (!digit_ok) begin
                        o_state.err_code = ST_SYNTAX;
                    end else begin
                        o_state.recent_index = digit;
                        o_state.recent_bank  = i_state.pending_bank ? BANK_A : BANK_D;
                        o_state.mask_accum   = i_state.mask_accum | single_bit;
                        o_state.phase        = PH_IDLE;
                    end
                end
                PH_RLETTER: begin
                    if ((i_state.recent_bank == BANK_D && i_char == ChD) ||
                        (i_state.recent_bank == BANK_A && i_char == ChA)) begin
                        o_state.phase = PH_RDIGIT;
                    end else begin
                        o_state.err_code = ST_SYNTAX;
                    end
                end
                PH_RDIGIT: begin
                    if (!digit_ok) begin
                        o_state.err_code = ST_SYNTAX;
                    end else begin
                        o_state.mask_accum   = i_state.mask_accum | range_bits;
                        o_state.recent_bank  = BANK_NONE;
                        o_state.recent_index = 3'd0;
                        o_state.phase        = PH_IDLE;
                    end
                end
                default: begin
                    o_state = i_state;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/register_list_mask_parser_unit.sv
`default_nettype none
// Register-list parser for MOVEM-style text such as "d0-d3/a5,a7". Characters
// arrive one per transfer on the slave side, tlast on the final one; each end
// of text yields one transfer on the master side carrying the 16-bit mask
// (d0-d7 in bits 0-7, a0-a7 in bits 8-15) and a status in tuser (0 ok,
// 1 bad register or range syntax, 2 unknown character; mask is 0 on error).
// One character is taken every cycle unless a final character is stalled; the
// parse state advances combinationally between the input and result registers.
// A result is registered as its final character leaves the input register.
// Characters keep flowing while a result waits to be taken; only the next
// final character stalls in the input register until that result is taken.
module register_list_mask_parser_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [rlmp_pkg::CharW-1:0]   s_axis_tdata,  // [7:0] char_code
    input  logic                         s_axis_tlast,  // end_of_text
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rlmp_pkg::MaskW-1:0]   m_axis_tdata,  // [15:0] reg_mask
    output logic [rlmp_pkg::StatusW-1:0] m_axis_tuser   // [1:0] status
);
    import rlmp_pkg::*;

    logic             r_in_vld;
    logic [CharW-1:0] r_in_char;
    logic             r_in_last;
    t_parse_state     r_state;
    t_parse_state     n_state;
    logic             r_out_vld;
    logic [MaskW-1:0] r_out_mask;
    t_status          r_out_status;
    t_status          fin_status;
    logic             out_free;
    logic             proc;
    logic             in_xfer;

    rlmp_step u_step (
        .i_state (r_state),
        .i_char  (r_in_char),
        .o_state (n_state)
    );

    assign out_free      = !r_out_vld || m_axis_tready;
    assign proc          = r_in_vld && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_vld || proc;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign fin_status = (n_state.err_code != ST_OK) ? n_state.err_code :
                        (n_state.phase != PH_IDLE)  ? ST_SYNTAX : ST_OK;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (proc && r_in_last) begin
            r_out_mask   <= (fin_status == ST_OK) ? n_state.mask_accum : '0;
            r_out_status <= fin_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= StateReset;
        end else begin
            if (in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            if (proc) begin
                r_state <= r_in_last ? StateReset : n_state;
            end
            if (proc && r_in_last) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_mask;
    assign m_axis_tuser  = r_out_status;

endmodule
`default_nettype wire

FILE: rtl/core/rlmp_checker.sv
`default_nettype none
module rlmp_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tready,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [rlmp_pkg::MaskW-1:0]   m_axis_tdata,
    input  logic [rlmp_pkg::StatusW-1:0] m_axis_tuser
);
    import rlmp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_SYNTAX
            || m_axis_tuser == ST_UNKNOWN))
        else $error("status out of range");

    a_err_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("mask not cleared on error");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

endmodule

bind register_list_mask_parser_unit rlmp_checker u_rlmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
